@@ src/sorted_table_binary_search_defines.svh @@
// assertion macros shared by the checker of sorted_table_binary_search
// no dependencies; expects clk and rst_n in the scope of each use
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// same-cycle implication, quiet during reset
`define STBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define STBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ src/stbs_pkg.sv @@
// types and constants of the sorted table search block
// no dependencies; used by every module of the block
package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int KEY_WIDTH   = 32;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int COUNT_W     = 11;
  localparam int POS_W       = 10;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_COMPARE = 1'd1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    MODE_ANY      = 3'd0,
    MODE_LOW_EQ   = 3'd1,
    MODE_HIGH_EQ  = 3'd2,
    MODE_LOWER    = 3'd3,
    MODE_UPPER    = 3'd4
  } mode_t;

  typedef struct packed {
    logic             op;
    logic [2:0]       search_mode;
    logic [POS_W-1:0] write_position;
    logic [31:0]      key_value;
  } in_item_t;

  typedef struct packed {
    logic               found;
    logic [COUNT_W-1:0] result_index;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic wr;
    logic load;
    logic probe;
    logic step;
    logic bound_done;
    logic final_rd;
    logic final_chk;
    logic out_load;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic span_zero;
    logic eq;
    logic mode_any;
    logic mode_bound;
    logic mode_eq_chk;
    logic final_ok;
  } dp_sts_t;

endpackage

@@ src/stbs_dp.sv @@
// datapath: config registers, table memory, search window and result registers
// depends on stbs_pkg
module stbs_dp (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  stbs_pkg::in_item_t               in_data,
  input  stbs_pkg::dp_cmd_t                cmd,
  output stbs_pkg::dp_sts_t                sts,
  output stbs_pkg::out_item_t              out_data
);

  localparam logic [stbs_pkg::COUNT_W-1:0] DEPTH_CNT = stbs_pkg::COUNT_W'(stbs_pkg::TABLE_DEPTH);
  localparam logic [stbs_pkg::KEY_WIDTH-1:0] SIGN_BIT =
    {1'b1, {(stbs_pkg::KEY_WIDTH-1){1'b0}}};

  logic [stbs_pkg::COUNT_W-1:0]   entry_count_r;
  logic                           signed_compare_r;

  logic [stbs_pkg::KEY_WIDTH-1:0] table_mem [stbs_pkg::TABLE_DEPTH];
  logic [stbs_pkg::KEY_WIDTH-1:0] rdata_r;

  logic [stbs_pkg::COUNT_W-1:0]   left_r;
  logic [stbs_pkg::COUNT_W-1:0]   span_r;
  logic [stbs_pkg::ADDR_W-1:0]    probe_r;
  logic [stbs_pkg::KEY_WIDTH-1:0] key_r;
  logic [2:0]                     mode_r;
  logic                           found_r;
  logic [stbs_pkg::COUNT_W-1:0]   idx_r;
  stbs_pkg::out_item_t            out_data_r;

  logic [stbs_pkg::COUNT_W-1:0]   n_cnt;
  logic [stbs_pkg::COUNT_W-1:0]   probe_calc;
  logic [stbs_pkg::COUNT_W-1:0]   left_m1;
  logic [stbs_pkg::ADDR_W-1:0]    fin_addr;
  logic [stbs_pkg::ADDR_W-1:0]    rd_addr;
  logic [stbs_pkg::KEY_WIDTH-1:0] flip;
  logic                           gt;
  logic                           eq;
  logic                           upper;
  logic                           wr_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r    <= '0;
      signed_compare_r <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        stbs_pkg::CFG_ENTRY_COUNT:    entry_count_r    <= cfg_wdata;
        stbs_pkg::CFG_SIGNED_COMPARE: signed_compare_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign n_cnt      = (entry_count_r > DEPTH_CNT) ? DEPTH_CNT : entry_count_r;
  assign probe_calc = left_r + (span_r >> 1);
  assign left_m1    = left_r - stbs_pkg::COUNT_W'(1);
  assign fin_addr   = (mode_r == stbs_pkg::MODE_HIGH_EQ) ? left_m1[stbs_pkg::ADDR_W-1:0]
                                                         : left_r[stbs_pkg::ADDR_W-1:0];
  assign rd_addr    = cmd.final_rd ? fin_addr : probe_calc[stbs_pkg::ADDR_W-1:0];
  assign wr_ok      = ({1'b0, in_data.write_position} < DEPTH_CNT);

  // two's complement order is unsigned order with the sign bit flipped
  assign flip  = signed_compare_r ? SIGN_BIT : '0;
  assign gt    = (key_r ^ flip) > (rdata_r ^ flip);
  assign eq    = (key_r == rdata_r);
  assign upper = (mode_r == stbs_pkg::MODE_HIGH_EQ) || (mode_r == stbs_pkg::MODE_UPPER);

  always_ff @(posedge clk) begin
    if (cmd.wr && wr_ok) begin
      table_mem[in_data.write_position[stbs_pkg::ADDR_W-1:0]] <=
        in_data.key_value[stbs_pkg::KEY_WIDTH-1:0];
    end
    rdata_r <= table_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      left_r  <= '0;
      span_r  <= n_cnt;
      key_r   <= in_data.key_value[stbs_pkg::KEY_WIDTH-1:0];
      mode_r  <= in_data.search_mode;
      found_r <= 1'b0;
      idx_r   <= '0;
    end
    if (cmd.probe) begin
      probe_r <= probe_calc[stbs_pkg::ADDR_W-1:0];
    end
    if (cmd.step) begin
      if ((mode_r == stbs_pkg::MODE_ANY) && eq) begin
        found_r <= 1'b1;
        idx_r   <= {1'b0, probe_r};
      end else if (gt || (upper && eq)) begin
        left_r <= {1'b0, probe_r} + stbs_pkg::COUNT_W'(1);
        span_r <= (span_r - stbs_pkg::COUNT_W'(1)) >> 1;
      end else begin
        span_r <= span_r >> 1;
      end
    end
    if (cmd.bound_done) begin
      found_r <= 1'b1;
      idx_r   <= left_r;
    end
    if (cmd.final_chk && eq) begin
      found_r <= 1'b1;
      idx_r   <= {1'b0, fin_addr};
    end
    if (cmd.out_load) begin
      out_data_r.found        <= found_r;
      out_data_r.result_index <= idx_r;
    end
  end

  assign sts.span_zero   = (span_r == '0);
  assign sts.eq          = eq;
  assign sts.mode_any    = (mode_r == stbs_pkg::MODE_ANY);
  assign sts.mode_bound  = (mode_r == stbs_pkg::MODE_LOWER) || (mode_r == stbs_pkg::MODE_UPPER);
  assign sts.mode_eq_chk = (mode_r == stbs_pkg::MODE_LOW_EQ) || (mode_r == stbs_pkg::MODE_HIGH_EQ);
  assign sts.final_ok    = (mode_r == stbs_pkg::MODE_LOW_EQ) ? (left_r < n_cnt)
                                                             : (left_r != '0);
  assign out_data        = out_data_r;

endmodule

@@ src/stbs_ctrl.sv @@
// controller: sequences write items, probes and the final equality check
// depends on stbs_pkg
module stbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  stbs_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output stbs_pkg::dp_cmd_t   cmd,
  input  stbs_pkg::dp_sts_t   sts
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FIN_CMP,
    ST_DONE
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.op == stbs_pkg::OP_WRITE) begin
            cmd.wr = 1'b1;
          end else begin
            cmd.load = 1'b1;
            // unknown modes answer not found right away
            state_nxt = (in_data.search_mode > stbs_pkg::MODE_UPPER) ? ST_DONE : ST_PROBE;
          end
        end
      end
      ST_PROBE: begin
        if (!sts.span_zero) begin
          cmd.probe = 1'b1;
          state_nxt = ST_CMP;
        end else if (sts.mode_bound) begin
          cmd.bound_done = 1'b1;
          state_nxt      = ST_DONE;
        end else if (sts.mode_eq_chk && sts.final_ok) begin
          cmd.final_rd = 1'b1;
          state_nxt    = ST_FIN_CMP;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_CMP: begin
        cmd.step  = 1'b1;
        state_nxt = (sts.mode_any && sts.eq) ? ST_DONE : ST_PROBE;
      end
      ST_FIN_CMP: begin
        cmd.final_chk = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

@@ src/sorted_table_binary_search.sv @@
// Sorted table search: write items (op 0) load one 32-bit key into a 1024-entry table and
// give no result; search items (op 1) look up a key among the first entry_count entries
// and give one result. Each probe is a registered table read followed by the compare and
// window update; the lowest-equal and highest-equal modes may end with a final read and
// equality check. Items are taken one at a time while the block is idle; a finished result
// waits in an output register and does not block the next item from being taken, but the
// next result waits for that register, stalling new items meanwhile. Table entries are
// undefined until written.
module sorted_table_binary_search (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  stbs_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output stbs_pkg::out_item_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [stbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [stbs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  stbs_pkg::dp_cmd_t cmd;
  stbs_pkg::dp_sts_t sts;

  stbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  stbs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

endmodule

@@ src/stbs_checker.sv @@
// port-level checks of sorted_table_binary_search, attached by bind
// depends on stbs_pkg and sorted_table_binary_search_defines.svh
`include "sorted_table_binary_search_defines.svh"

module stbs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input stbs_pkg::in_item_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input stbs_pkg::out_item_t out_data
);

  `STBS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `STBS_ASSERT_NOW(a_miss_zero, out_valid && !out_data.found, out_data.result_index == '0, "miss with nonzero index")
  `STBS_ASSERT_NOW(a_idx_range, out_valid, out_data.result_index <= 11'd1024, "index beyond table")
  `STBS_ASSERT_NEXT(a_search_busy, in_valid && !in_stall && (in_data.op == stbs_pkg::OP_SEARCH), in_stall, "search transfer left block ready")

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

@@ verif/sorted_table_binary_search_test.sv @@
// testbench for sorted_table_binary_search: table loads and five-mode key searches,
// checked against a behavioral search predictor, with random gaps and output stalls
// depends on stbs_pkg and the sorted_table_binary_search rtl
`timescale 1ns / 100ps

module sorted_table_binary_search_test;

  localparam int SETTLE_CYCLES  = 40;
  localparam int HOLD_CYCLES    = 300;
  localparam int RANDOM_ITEMS   = 150;
  localparam int PRESSURE_PHASE = 1;
  localparam int TIMEOUT_NS     = 40_000_000;
  localparam int COUNT_MAX      = (1 << stbs_pkg::CFG_DATA_W) - 1;
  localparam logic [stbs_pkg::KEY_WIDTH-1:0] SIGN_BIT = 1 << (stbs_pkg::KEY_WIDTH - 1);

  typedef struct {
    bit                              is_cfg;
    logic [stbs_pkg::CFG_IDX_W-1:0]  idx;
    logic [stbs_pkg::CFG_DATA_W-1:0] val;
    stbs_pkg::in_item_t              item;
    bit                              typed;
    stbs_pkg::out_item_t             exp;
  } row_t;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_stall;
  stbs_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_stall;
  stbs_pkg::out_item_t             out_data;
  logic                            cfg_wr_en;
  logic [stbs_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [stbs_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // predictor state
  logic [stbs_pkg::KEY_WIDTH-1:0] tbl [stbs_pkg::TABLE_DEPTH];
  int unsigned                    cfg_count = 0;
  bit                             cfg_sgn = 1'b0;

  stbs_pkg::out_item_t pending_results[$];
  stbs_pkg::out_item_t want;
  int unsigned         fail_count = 0;
  int unsigned         transfers = 0;
  bit                  quiet_phase = 1'b0;
  bit                  hold_req = 1'b0;

  sorted_table_binary_search dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // flip the sign bit so signed order becomes unsigned order
  function automatic logic [stbs_pkg::KEY_WIDTH-1:0] key_order(
      logic [stbs_pkg::KEY_WIDTH-1:0] k);
    return cfg_sgn ? (k ^ SIGN_BIT) : k;
  endfunction

  function automatic int unsigned bound_pos(logic [stbs_pkg::KEY_WIDTH-1:0] key,
                                            int unsigned n, bit upper);
    int unsigned left, span, probe;
    left = 0;
    span = n;
    while (span > 0) begin
      probe = left + span / 2;
      if (key_order(key) > key_order(tbl[probe]) ||
          (upper && key == tbl[probe])) begin
        left = probe + 1;
        span--;
      end
      span = span / 2;
    end
    return left;
  endfunction

  function automatic stbs_pkg::out_item_t search_outcome(logic [2:0] mode,
      logic [stbs_pkg::KEY_WIDTH-1:0] key);
    stbs_pkg::out_item_t r;
    int unsigned         n, left, span, probe, b;
    r = '0;
    n = (cfg_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : cfg_count;
    case (mode)
      stbs_pkg::MODE_ANY: begin
        left = 0;
        span = n;
        while (span > 0) begin
          probe = left + span / 2;
          if (key == tbl[probe]) begin
            r.found = 1'b1;
            r.result_index = stbs_pkg::COUNT_W'(probe);
            span = 0;
          end else begin
            if (key_order(key) > key_order(tbl[probe])) begin
              left = probe + 1;
              span--;
            end
            span = span / 2;
          end
        end
      end
      stbs_pkg::MODE_LOW_EQ: begin
        b = bound_pos(key, n, 1'b0);
        if (b < n && tbl[b] == key) begin
          r.found = 1'b1;
          r.result_index = stbs_pkg::COUNT_W'(b);
        end
      end
      stbs_pkg::MODE_HIGH_EQ: begin
        b = bound_pos(key, n, 1'b1);
        if (b > 0 && tbl[b-1] == key) begin
          r.found = 1'b1;
          r.result_index = stbs_pkg::COUNT_W'(b - 1);
        end
      end
      stbs_pkg::MODE_LOWER: begin
        r.found = 1'b1;
        r.result_index = stbs_pkg::COUNT_W'(bound_pos(key, n, 1'b0));
      end
      stbs_pkg::MODE_UPPER: begin
        r.found = 1'b1;
        r.result_index = stbs_pkg::COUNT_W'(bound_pos(key, n, 1'b1));
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_phase || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(10, 40);
  endfunction

  function automatic row_t row_item(logic op, logic [2:0] mode,
                                    logic [stbs_pkg::POS_W-1:0] pos,
                                    logic [stbs_pkg::KEY_WIDTH-1:0] key, bit typed, logic f,
                                    int unsigned idx);
    row_t r;
    r = '{default: '0};
    r.item.op = op;
    r.item.search_mode = mode;
    r.item.write_position = pos;
    r.item.key_value = key;
    r.typed = typed;
    r.exp.found = f;
    r.exp.result_index = stbs_pkg::COUNT_W'(idx);
    return r;
  endfunction

  function automatic row_t row_cfg(logic [stbs_pkg::CFG_IDX_W-1:0] idx,
                                   logic [stbs_pkg::CFG_DATA_W-1:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  // offer one item and hold it until the transfer, then update the predictor
  task automatic send(stbs_pkg::in_item_t it, bit typed, stbs_pkg::out_item_t given);
    int unsigned gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    transfers++;
    if (it.op == stbs_pkg::OP_WRITE)
      tbl[it.write_position] = it.key_value;
    else
      pending_results.push_back(typed ? given : search_outcome(it.search_mode, it.key_value));
  endtask

  // wait until every result is back, then let a trailing write finish
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [stbs_pkg::CFG_IDX_W-1:0] idx,
                           logic [stbs_pkg::CFG_DATA_W-1:0] val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == stbs_pkg::CFG_ENTRY_COUNT)
      cfg_count = val;
    else
      cfg_sgn = val[0];
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // ascending keys in the current compare order, with runs of duplicates
  task automatic load_sorted(int unsigned ntab);
    logic [32:0]        ord;
    logic [31:0]        step_max;
    stbs_pkg::in_item_t it;
    int unsigned        p;
    step_max = ($urandom_range(0, 1) == 0) ? 32'd2 : 32'hFFFF_FFFF / (ntab + 1);
    ord = ($urandom_range(0, 3) == 0) ? 33'd0 : ({1'b0, $urandom} >> $urandom_range(0, 31));
    for (p = 0; p < ntab; p++) begin
      if (p == ntab - 1 && $urandom_range(0, 3) == 0) ord = 33'h0_FFFF_FFFF;
      it.op = stbs_pkg::OP_WRITE;
      it.search_mode = 3'($urandom);
      it.write_position = stbs_pkg::POS_W'(p);
      it.key_value = ord[31:0] ^ (cfg_sgn ? SIGN_BIT : '0);
      send(it, 1'b0, '0);
      if ($urandom_range(0, 3) != 0) ord = ord + $urandom_range(0, step_max);
      if (ord > 33'h0_FFFF_FFFF) ord = 33'h0_FFFF_FFFF;
    end
  endtask

  task automatic search_burst(int unsigned k);
    stbs_pkg::in_item_t it;
    int unsigned        n, r;
    n = (cfg_count > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : cfg_count;
    repeat (k) begin
      it.op = stbs_pkg::OP_SEARCH;
      it.search_mode = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                   : 3'($urandom_range(0, 4));
      it.write_position = stbs_pkg::POS_W'($urandom);
      r = $urandom_range(0, 99);
      if (n != 0 && r < 55)
        it.key_value = tbl[$urandom_range(0, n - 1)];
      else if (n != 0 && r < 75)
        it.key_value = tbl[$urandom_range(0, n - 1)] +
                       (($urandom_range(0, 1) == 0) ? 32'd1 : 32'hFFFF_FFFF);
      else if (r < 85)
        case ($urandom_range(0, 3))
          0: it.key_value = '0;
          1: it.key_value = '1;
          2: it.key_value = 32'h7FFF_FFFF;
          default: it.key_value = 32'h8000_0000;
        endcase
      else
        it.key_value = $urandom;
      // occasional stray write, which may leave the table unsorted
      if ($urandom_range(0, 9) == 0) begin
        it.op = stbs_pkg::OP_WRITE;
        it.key_value = $urandom;
      end
      send(it, 1'b0, '0);
    end
  endtask

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_side
    int unsigned r, len;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else if (quiet_phase) begin
        out_stall <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 60) begin
          out_stall <= 1'b0;
          len = $urandom_range(1, 20);
        end else begin
          out_stall <= 1'b1;
          if (r < 90) len = $urandom_range(1, 3);
          else if (r < 98) len = $urandom_range(4, 15);
          else len = $urandom_range(20, 60);
        end
        repeat (len - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with none pending: found=%0b result_index=%0d",
               out_data.found, out_data.result_index);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_data.found !== want.found) begin
          $error("found: expected %0b, got %0b", want.found, out_data.found);
          fail_count++;
        end
        if (out_data.result_index !== want.result_index) begin
          $error("result_index: expected %0d, got %0d",
                 want.result_index, out_data.result_index);
          fail_count++;
        end
      end
    end
  end

  initial begin : stimulus
    row_t        plan[$];
    int unsigned m, r, cnt, ntab, k, stop_at, phase;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // empty table after reset: only the bound modes report found
    for (m = 0; m < 8; m++)
      plan.push_back(row_item(stbs_pkg::OP_SEARCH, 3'(m), stbs_pkg::POS_W'(m * 146),
                              (m % 2) ? '1 : '0, 1'b1,
                              3'(m) == stbs_pkg::MODE_LOWER || 3'(m) == stbs_pkg::MODE_UPPER,
                              0));
    // unsigned table 0, 20, 20, max
    plan.push_back(row_cfg(stbs_pkg::CFG_ENTRY_COUNT, 11'd4));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd7, 10'd0, 32'd0, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd1, 32'd20, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd2, 32'd20, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd3, 32'hFFFF_FFFF, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_LOW_EQ, 10'd0, 32'd20,
                            1'b1, 1'b1, 1));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_HIGH_EQ, 10'h3FF, 32'd20,
                            1'b1, 1'b1, 2));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_ANY, 10'd0, 32'd21,
                            1'b1, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_UPPER, 10'd0, 32'hFFFF_FFFF,
                            1'b1, 1'b1, 4));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_LOWER, 10'd0, 32'd0,
                            1'b1, 1'b1, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'h3FF, 32'hFFFF_FFFF, 1'b0, 1'b0, 0));
    // signed table min, -1, -1, max
    plan.push_back(row_cfg(stbs_pkg::CFG_SIGNED_COMPARE, 11'd1));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd0, 32'h8000_0000, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd1, 32'hFFFF_FFFF, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd2, 32'hFFFF_FFFF, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_WRITE, 3'd0, 10'd3, 32'h7FFF_FFFF, 1'b0, 1'b0, 0));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_LOW_EQ, 10'd0, 32'hFFFF_FFFF,
                            1'b1, 1'b1, 1));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_HIGH_EQ, 10'd0, 32'hFFFF_FFFF,
                            1'b1, 1'b1, 2));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_UPPER, 10'd0, 32'h7FFF_FFFF,
                            1'b1, 1'b1, 4));
    plan.push_back(row_item(stbs_pkg::OP_SEARCH, stbs_pkg::MODE_LOWER, 10'd0, 32'h8000_0000,
                            1'b1, 1'b1, 0));

    foreach (plan[i]) begin
      if (plan[i].is_cfg)
        cfg_write(plan[i].idx, plan[i].val);
      else
        send(plan[i].item, plan[i].typed, plan[i].exp);
    end

    // fill the whole table once, so any entry count is safe from here on
    cfg_write(stbs_pkg::CFG_SIGNED_COMPARE, stbs_pkg::CFG_DATA_W'($urandom_range(0, 1)));
    cfg_write(stbs_pkg::CFG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(stbs_pkg::TABLE_DEPTH));
    load_sorted(stbs_pkg::TABLE_DEPTH);
    search_burst(60);
    // count past the table depth saturates
    cfg_write(stbs_pkg::CFG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(COUNT_MAX));
    search_burst(30);

    stop_at = transfers + RANDOM_ITEMS;
    phase = 0;
    while (transfers < stop_at) begin
      phase++;
      quiet_phase = 1'b0;
      r = $urandom_range(0, 99);
      if (r < 5) cnt = 0;
      else if (r < 10) cnt = $urandom_range(stbs_pkg::TABLE_DEPTH, COUNT_MAX);
      else if (r < 15) cnt = 1;
      else if (r < 80) cnt = $urandom_range(2, 16);
      else cnt = $urandom_range(17, 200);
      cfg_write(stbs_pkg::CFG_SIGNED_COMPARE, stbs_pkg::CFG_DATA_W'($urandom_range(0, 1)));
      cfg_write(stbs_pkg::CFG_ENTRY_COUNT, stbs_pkg::CFG_DATA_W'(cnt));
      quiet_phase = ($urandom_range(0, 99) < 15);
      ntab = (cnt > stbs_pkg::TABLE_DEPTH) ? stbs_pkg::TABLE_DEPTH : cnt;
      if (ntab <= 200 && $urandom_range(0, 99) < 85) load_sorted(ntab);
      k = $urandom_range(5, 30);
      if (phase == PRESSURE_PHASE) begin
        // results back up while items keep coming
        quiet_phase = 1'b1;
        hold_req = 1'b1;
        k = 40;
      end
      search_burst(k);
    end

    quiet_phase = 1'b0;
    drain();
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/stbs_pkg.sv
src/stbs_dp.sv
src/stbs_ctrl.sv
src/sorted_table_binary_search.sv
src/stbs_checker.sv
verif/sorted_table_binary_search_test.sv
